// File: rtl/ksc_pkg.sv
// Package for the key slot cache: item types, operation and status codes,
// default table sizes. No dependencies.

package ksc_pkg;

   // default table geometry
   localparam int KSC_ENTRIES   = 16;
   localparam int KSC_KEY_WORDS = 4;

   // operation codes
   localparam logic [2:0] OP_ALLOC    = 3'd0;
   localparam logic [2:0] OP_RELEASE  = 3'd1;
   localparam logic [2:0] OP_STORE    = 3'd2;
   localparam logic [2:0] OP_RETRIEVE = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;
   localparam logic [2:0] OP_ENABLE   = 3'd5;
   localparam logic [2:0] OP_DISABLE  = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_ALLOC  = 3'd1;
   localparam logic [2:0] ST_NO_KEY     = 3'd2;
   localparam logic [2:0] ST_DISABLED   = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  slot;
      logic [1:0]  word_index;
      logic [63:0] data_word;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  result_slot;
      logic [1:0]  result_word_index;
      logic [63:0] key_word_out;
      logic        last_result;
   } rsp_type;

endpackage

// File: rtl/key_slot_cache_with_idle_expiry.sv
// Key slot cache with idle expiry. A new item is taken only in the idle state, while req_stall
// is low. An unknown code is dropped; release of a free slot, store, retrieve error and enable
// go straight to the result; retrieve of a valid key reads memory, then outputs, per returned
// word; allocate scans for the lowest free slot, then zeroes its words; release zeroes its
// words; tick and disable sweep the whole memory. Reset clears all slot marks and turns
// the cache on; the key memory is not cleared (every slot is zeroed when it is allocated).

module key_slot_cache_with_idle_expiry
   import ksc_pkg::*;
#(
   parameter int ENTRIES   = KSC_ENTRIES,
   parameter int KEY_WORDS = KSC_KEY_WORDS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // index widths
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WORD_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int DEPTH  = ENTRIES * KEY_WORDS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXT_W  = IDX_W + 4;
   // a retrieve returns at most four words
   localparam int NOUT   = (KEY_WORDS < 4) ? KEY_WORDS : 4;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIND  = 7'b0000010,
      S_ZERO  = 7'b0000100,
      S_SWEEP = 7'b0001000,
      S_READ  = 7'b0010000,
      S_PUT   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   // key words, slot-major: address = slot * KEY_WORDS + word
   logic [63:0] key_mem [DEPTH];

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;     // working slot / scan / sweep counter
   logic [WORD_W-1:0]    wcnt_ff, wcnt_in;     // word counter for zero and sweep
   logic [1:0]           rcnt_ff, rcnt_in;     // retrieve word counter
   logic [ENTRIES-1:0]   mask_ff, mask_in;     // slots to erase in a sweep
   rsp_type              res_ff, res_in;       // pending single result
   logic [ENTRIES-1:0]   in_use_ff, in_use_in;
   logic [ENTRIES-1:0]   holds_ff, holds_in;
   logic [ENTRIES-1:0]   recent_ff, recent_in;
   logic                 cache_on_ff, cache_on_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [63:0]          rd_data_ff;

   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [63:0]          mem_wdata;

   logic                 out_free;
   logic [EXT_W-1:0]     slot_ext;
   logic [IDX_W-1:0]     req_idx;
   logic                 ok_slot;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [IDX_W-1:0] s,
                                                   input logic [ADDR_W-1:0] w);
      return ADDR_W'(s * KEY_WORDS) + w;
   endfunction

   function automatic rsp_type mk_rsp(input logic [2:0] st, input logic [3:0] sl,
                                      input logic [1:0] wi, input logic [63:0] kw,
                                      input logic lst);
      rsp_type r;
      r.status            = st;
      r.result_slot       = sl;
      r.result_word_index = wi;
      r.key_word_out      = kw;
      r.last_result       = lst;
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   // output register can take a new item this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // slot field checked against the table size before indexing
   assign slot_ext = EXT_W'(req_data.slot);
   assign req_idx  = slot_ext[IDX_W-1:0];
   assign ok_slot  = (slot_ext < EXT_W'(ENTRIES)) && in_use_ff[req_idx];

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      wcnt_in      = wcnt_ff;
      rcnt_in      = rcnt_ff;
      mask_in      = mask_ff;
      res_in       = res_ff;
      in_use_in    = in_use_ff;
      holds_in     = holds_ff;
      recent_in    = recent_ff;
      cache_on_in  = cache_on_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = word_addr(slot_ff, ADDR_W'(wcnt_ff));
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = word_addr(slot_ff, ADDR_W'(rcnt_ff));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  OP_ALLOC: begin
                     slot_in  = '0;
                     state_in = S_FIND;
                  end
                  OP_RELEASE: begin
                     if (!ok_slot) begin
                        res_in   = mk_rsp(ST_NOT_ALLOC, req_data.slot, 2'd0, '0, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        in_use_in[req_idx] = 1'b0;
                        holds_in[req_idx]  = 1'b0;
                        recent_in[req_idx] = 1'b0;
                        slot_in  = req_idx;
                        wcnt_in  = '0;
                        res_in   = mk_rsp(ST_OK, req_data.slot, 2'd0, '0, 1'b1);
                        state_in = S_ZERO;
                     end
                  end
                  OP_STORE: begin
                     state_in = S_EMIT;
                     if (!cache_on_ff) begin
                        res_in = mk_rsp(ST_DISABLED, req_data.slot,
                                        req_data.word_index, '0, 1'b1);
                     end else if (!ok_slot) begin
                        res_in = mk_rsp(ST_NOT_ALLOC, req_data.slot,
                                        req_data.word_index, '0, 1'b1);
                     end else begin
                        // words past the key length are dropped
                        mem_we    = (32'(req_data.word_index) < KEY_WORDS);
                        mem_waddr = word_addr(req_idx, ADDR_W'(req_data.word_index));
                        mem_wdata = req_data.data_word;
                        if (req_data.last_word) begin
                           holds_in[req_idx]  = 1'b1;
                           recent_in[req_idx] = 1'b1;
                        end
                        res_in = mk_rsp(ST_OK, req_data.slot,
                                        req_data.word_index, '0, 1'b1);
                     end
                  end
                  OP_RETRIEVE: begin
                     if (!cache_on_ff) begin
                        res_in   = mk_rsp(ST_DISABLED, req_data.slot, 2'd0, '0, 1'b1);
                        state_in = S_EMIT;
                     end else if (!ok_slot) begin
                        res_in   = mk_rsp(ST_NOT_ALLOC, req_data.slot, 2'd0, '0, 1'b1);
                        state_in = S_EMIT;
                     end else if (!holds_ff[req_idx]) begin
                        res_in   = mk_rsp(ST_NO_KEY, req_data.slot, 2'd0, '0, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        recent_in[req_idx] = 1'b1;
                        slot_in  = req_idx;
                        rcnt_in  = '0;
                        state_in = S_READ;
                     end
                  end
                  OP_TICK: begin
                     // second chance: erase idle keys, clear all accessed marks
                     mask_in   = holds_ff & ~recent_ff;
                     holds_in  = holds_ff & recent_ff;
                     recent_in = '0;
                     slot_in   = '0;
                     wcnt_in   = '0;
                     res_in    = mk_rsp(ST_OK, 4'd0, 2'd0, '0, 1'b1);
                     state_in  = S_SWEEP;
                  end
                  OP_ENABLE: begin
                     cache_on_in = 1'b1;
                     res_in      = mk_rsp(ST_OK, 4'd0, 2'd0, '0, 1'b1);
                     state_in    = S_EMIT;
                  end
                  OP_DISABLE: begin
                     // erase every key, slots stay allocated
                     mask_in     = holds_ff;
                     holds_in    = '0;
                     recent_in   = '0;
                     cache_on_in = 1'b0;
                     slot_in     = '0;
                     wcnt_in     = '0;
                     res_in      = mk_rsp(ST_OK, 4'd0, 2'd0, '0, 1'b1);
                     state_in    = S_SWEEP;
                  end
                  default: begin
                     // unused code: no effect, no result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIND: begin
            // lowest free slot, one slot per cycle
            if (!in_use_ff[slot_ff]) begin
               in_use_in[slot_ff] = 1'b1;
               holds_in[slot_ff]  = 1'b0;
               recent_in[slot_ff] = 1'b0;
               wcnt_in  = '0;
               res_in   = mk_rsp(ST_OK, 4'(slot_ff), 2'd0, '0, 1'b1);
               state_in = S_ZERO;
            end else if (slot_ff == IDX_W'(ENTRIES - 1)) begin
               res_in   = mk_rsp(ST_TABLE_FULL, 4'd0, 2'd0, '0, 1'b1);
               state_in = S_EMIT;
            end else begin
               slot_in = slot_ff + IDX_W'(1);
            end
         end
         S_ZERO: begin
            mem_we = 1'b1;
            if (wcnt_ff == WORD_W'(KEY_WORDS - 1)) begin
               state_in = S_EMIT;
            end else begin
               wcnt_in = wcnt_ff + WORD_W'(1);
            end
         end
         S_SWEEP: begin
            mem_we = mask_ff[slot_ff];
            if (wcnt_ff == WORD_W'(KEY_WORDS - 1)) begin
               wcnt_in = '0;
               if (slot_ff == IDX_W'(ENTRIES - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  slot_in = slot_ff + IDX_W'(1);
               end
            end else begin
               wcnt_in = wcnt_ff + WORD_W'(1);
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mk_rsp(ST_OK, 4'(slot_ff), rcnt_ff, rd_data_ff,
                                     rcnt_ff == 2'(NOUT - 1));
               if (rcnt_ff == 2'(NOUT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  rcnt_in  = rcnt_ff + 2'd1;
                  state_in = S_READ;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         holds_ff     <= '0;
         recent_ff    <= '0;
         cache_on_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         holds_ff     <= holds_in;
         recent_ff    <= recent_in;
         cache_on_ff  <= cache_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      wcnt_ff     <= wcnt_in;
      rcnt_ff     <= rcnt_in;
      mask_ff     <= mask_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // key word memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= key_mem[mem_raddr];
      end
   end

endmodule

// File: bench/key_cache_checker.sv
// Result checker for the key slot cache: follows accepted items, predicts the
// result words they cause and compares them with the block's output.
// Depends on ksc_pkg.

module key_cache_checker
   import ksc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   localparam int SLOTS   = KSC_ENTRIES;
   localparam int WORDS   = KSC_KEY_WORDS;
   localparam int MAX_RUN = 4;   // longest word run a retrieve returns

   logic [63:0] key_store [SLOTS][WORDS];
   bit          slot_used    [SLOTS];
   bit          slot_loaded  [SLOTS];
   bit          slot_touched [SLOTS];
   bit          cache_enabled;
   rsp_type     awaited_results [$];

   initial failures = 0;
   initial pending  = 0;

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
      failures++;
   endtask

   task automatic expect_result(input logic [2:0] status, input logic [3:0] slot,
                                input logic [1:0] widx, input logic [63:0] word,
                                input logic last);
      rsp_type r;
      r.status            = status;
      r.result_slot       = slot;
      r.result_word_index = widx;
      r.key_word_out      = word;
      r.last_result       = last;
      awaited_results.push_back(r);
   endtask

   task automatic erase_slot(input int s);
      for (int w = 0; w < WORDS; w++) key_store[s][w] = '0;
   endtask

   // second-chance sweep; wipe_all drops every key regardless of use
   task automatic sweep(input bit wipe_all);
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_loaded[s] && (wipe_all || !slot_touched[s])) begin
            erase_slot(s);
            slot_loaded[s] = 1'b0;
         end
         slot_touched[s] = 1'b0;
      end
   endtask

   task automatic apply_request(input req_type item);
      bit placed;
      int n;
      placed = 1'b0;
      n = WORDS < MAX_RUN ? WORDS : MAX_RUN;
      case (item.operation)
         OP_ALLOC: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!placed && !slot_used[s]) begin
                  slot_used[s]    = 1'b1;
                  slot_loaded[s]  = 1'b0;
                  slot_touched[s] = 1'b0;
                  erase_slot(s);
                  expect_result(ST_OK, 4'(s), 2'd0, '0, 1'b1);
                  placed = 1'b1;
               end
            end
            if (!placed) expect_result(ST_TABLE_FULL, 4'd0, 2'd0, '0, 1'b1);
         end
         OP_RELEASE: begin
            if (!slot_used[item.slot]) begin
               expect_result(ST_NOT_ALLOC, item.slot, 2'd0, '0, 1'b1);
            end else begin
               slot_used[item.slot]    = 1'b0;
               slot_loaded[item.slot]  = 1'b0;
               slot_touched[item.slot] = 1'b0;
               erase_slot(int'(item.slot));
               expect_result(ST_OK, item.slot, 2'd0, '0, 1'b1);
            end
         end
         OP_STORE: begin
            if (!cache_enabled) begin
               expect_result(ST_DISABLED, item.slot, item.word_index, '0, 1'b1);
            end else if (!slot_used[item.slot]) begin
               expect_result(ST_NOT_ALLOC, item.slot, item.word_index, '0, 1'b1);
            end else begin
               if (item.word_index < WORDS)
                  key_store[item.slot][item.word_index] = item.data_word;
               if (item.last_word) begin
                  slot_loaded[item.slot]  = 1'b1;
                  slot_touched[item.slot] = 1'b1;
               end
               expect_result(ST_OK, item.slot, item.word_index, '0, 1'b1);
            end
         end
         OP_RETRIEVE: begin
            if (!cache_enabled) begin
               expect_result(ST_DISABLED, item.slot, 2'd0, '0, 1'b1);
            end else if (!slot_used[item.slot]) begin
               expect_result(ST_NOT_ALLOC, item.slot, 2'd0, '0, 1'b1);
            end else if (!slot_loaded[item.slot]) begin
               expect_result(ST_NO_KEY, item.slot, 2'd0, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  expect_result(ST_OK, item.slot, 2'(i), key_store[item.slot][i],
                                i == n - 1);
               slot_touched[item.slot] = 1'b1;
            end
         end
         OP_TICK: begin
            sweep(1'b0);
            expect_result(ST_OK, 4'd0, 2'd0, '0, 1'b1);
         end
         OP_ENABLE: begin
            cache_enabled = 1'b1;
            expect_result(ST_OK, 4'd0, 2'd0, '0, 1'b1);
         end
         OP_DISABLE: begin
            sweep(1'b1);
            cache_enabled = 1'b0;
            expect_result(ST_OK, 4'd0, 2'd0, '0, 1'b1);
         end
         default: ;   // unused code: ignored, no result
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_used[s]    = 1'b0;
            slot_loaded[s]  = 1'b0;
            slot_touched[s] = 1'b0;
         end
         cache_enabled = 1'b1;
         awaited_results.delete();
      end else begin
         // results first: none can leave in the cycle its item enters
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report("unexpected result", rsp_data.key_word_out, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.result_slot !== want.result_slot)
                  report("result_slot", 64'(rsp_data.result_slot),
                         64'(want.result_slot));
               if (rsp_data.result_word_index !== want.result_word_index)
                  report("result_word_index", 64'(rsp_data.result_word_index),
                         64'(want.result_word_index));
               if (rsp_data.key_word_out !== want.key_word_out)
                  report("key_word_out", rsp_data.key_word_out, want.key_word_out);
               if (rsp_data.last_result !== want.last_result)
                  report("last_result", 64'(rsp_data.last_result),
                         64'(want.last_result));
            end
         end
         if (req_valid && !req_stall) apply_request(req_data);
      end
      pending <= awaited_results.size();
   end

endmodule

// File: bench/testbench.sv
// Bench top for the key slot cache: clock, reset, item stimulus, idle and
// stall phases, verdict. Depends on ksc_pkg, key_slot_cache_with_idle_expiry
// and key_cache_checker.

module testbench;
   import ksc_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;   // code the block ignores
   localparam int CYCLE_LIMIT = 400000;       // far above the slowest correct run
   localparam int ITEM_TARGET = 360;          // directed part plus random items
   localparam int HOLD_CYCLES = 400;          // long receiver hold-off
   localparam int DRAIN_CYCLES = 100;         // covers a full sweep after the last result

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int   phase      = 0;     // 0: sender idles lightly, receiver heavily; 1: reversed; 2: none
   logic hold_off   = 1'b0;
   int   cycles     = 0;
   int   items_sent = 0;     // ignored items are not counted
   bit   slot_taken [KSC_ENTRIES];   // allocation mirror, steers well-formed sequences
   int   failures;
   int   pending;

   always #6 clock = ~clock;

   key_slot_cache_with_idle_expiry u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   key_cache_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   // Watchdog: a hang or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stall by phase, plus the forced hold-off.
   // phase and hold_off only change by nonblocking writes, so the value read
   // here is the one from before the edge.
   always @(posedge clock) begin
      rsp_stall <= hold_off ||
                   ($urandom_range(99) < (phase == 0 ? 71 : phase == 1 ? 16 : 0));
   end

   // Long hold-off at the start of the no-idle phase: the sender keeps
   // offering items, so the block backs up and raises req_stall.
   initial begin
      wait (phase == 2);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic logic [63:0] random_word();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly an allocated slot; otherwise any slot, to hit the error paths.
   function automatic logic [3:0] pick_slot();
      int taken [$];
      for (int s = 0; s < KSC_ENTRIES; s++)
         if (slot_taken[s]) taken.push_back(s);
      if (taken.size() == 0 || $urandom_range(9) == 0)
         return 4'($urandom_range(15));
      return 4'(taken[$urandom_range(taken.size() - 1)]);
   endfunction

   // Offer one item and hold it until accepted. Idle gaps go in front of the
   // item; with no gap valid simply stays high and the payload moves on.
   task automatic send(input logic [2:0] op, input logic [3:0] slot,
                       input logic [1:0] widx, input logic [63:0] word,
                       input logic last);
      req_type item;
      bit placed;
      item.operation  = op;
      item.slot       = slot;
      item.word_index = widx;
      item.data_word  = word;
      item.last_word  = last;
      while ($urandom_range(99) < (phase == 0 ? 16 : phase == 1 ? 71 : 0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // keep the allocation mirror in step with the block
      placed = 1'b0;
      if (op == OP_ALLOC) begin
         for (int s = 0; s < KSC_ENTRIES; s++) begin
            if (!placed && !slot_taken[s]) begin
               slot_taken[s] = 1'b1;
               placed = 1'b1;
            end
         end
      end else if (op == OP_RELEASE) begin
         slot_taken[slot] = 1'b0;
      end
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Key store as a word sequence; now and then partial, rotated, or missing
   // the last-word mark.
   task automatic write_key(input logic [3:0] slot);
      int count;
      int start;
      bit broken;
      count  = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : KSC_KEY_WORDS;
      start  = $urandom_range(1) ? 0 : $urandom_range(3);
      broken = ($urandom_range(9) == 0);
      for (int i = 0; i < count; i++)
         send(OP_STORE, slot, 2'((start + i) % KSC_KEY_WORDS), random_word(),
              (i == count - 1) && !broken);
   endtask

   // Allocate until full, push past it, then free a few slots again.
   task automatic fill_table();
      int free_slots;
      free_slots = 0;
      for (int s = 0; s < KSC_ENTRIES; s++)
         if (!slot_taken[s]) free_slots++;
      repeat (free_slots + $urandom_range(1, 2)) send(OP_ALLOC, '0, '0, '0, 1'b0);
      repeat ($urandom_range(4, 10)) send(OP_RELEASE, pick_slot(), '0, '0, 1'b0);
   endtask

   initial begin
      int pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send(OP_TICK,     4'd0,  2'd0, '0, 1'b0);   // sweep of an empty table
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // not allocated
      send(OP_RELEASE,  4'd15, 2'd0, '0, 1'b0);   // not allocated, top slot
      send(OP_STORE,    4'd9,  2'd2, '1, 1'b1);   // store to a free slot
      send(OP_ALLOC,    4'd0,  2'd0, '0, 1'b0);   // gets slot 0
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // allocated but no key yet
      send(OP_STORE,    4'd0,  2'd0, '1, 1'b0);
      send(OP_STORE,    4'd0,  2'd1, '0, 1'b0);
      send(OP_STORE,    4'd0,  2'd2, 64'h0123_4567_89ab_cdef, 1'b0);
      send(OP_STORE,    4'd0,  2'd3, 64'h8000_0000_0000_0001, 1'b1);
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // four-word run
      send(OP_STORE,    4'd0,  2'd1, 64'h5555_aaaa_5555_aaaa, 1'b0);  // over a live key
      send(OP_TICK,     4'd0,  2'd0, '0, 1'b0);   // recently used: survives
      send(OP_TICK,     4'd0,  2'd0, '0, 1'b0);   // idle since last tick: expires
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // key gone
      send(OP_STORE,    4'd0,  2'd2, 64'hfedc_ba98_7654_3210, 1'b1);  // one-word key
      send(OP_DISABLE,  4'd0,  2'd0, '0, 1'b0);   // erases all keys
      send(OP_STORE,    4'd0,  2'd3, '1, 1'b1);   // disabled
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // disabled
      send(OP_ALLOC,    4'd0,  2'd0, '0, 1'b0);   // allocate still works while off
      send(OP_UNUSED,   4'd5,  2'd1, '1, 1'b1);   // ignored code, no result
      send(OP_ENABLE,   4'd0,  2'd0, '0, 1'b0);
      send(OP_RETRIEVE, 4'd0,  2'd0, '0, 1'b0);   // disable wiped the key
      send(OP_RELEASE,  4'd0,  2'd0, '0, 1'b0);
      send(OP_RELEASE,  4'd0,  2'd0, '0, 1'b0);   // double release

      // ---- random part: mostly well-formed sequences, some noise ----
      fill_table();   // reach the table-full answer early
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 240 && phase != 2)
            phase <= 2;
         else if (items_sent >= 120 && phase == 0)
            phase <= 1;
         pick = $urandom_range(99);
         if (pick < 10)
            send(OP_ALLOC, 4'($urandom_range(15)), '0, '0, 1'b0);
         else if (pick < 35)
            write_key(pick_slot());
         else if (pick < 58)
            send(OP_RETRIEVE, pick_slot(), '0, '0, 1'b0);
         else if (pick < 68)
            send(OP_RELEASE, pick_slot(), '0, '0, 1'b0);
         else if (pick < 77)
            send(OP_TICK, 4'($urandom_range(15)), '0, '0, 1'b0);
         else if (pick < 80)
            send(OP_DISABLE, 4'($urandom_range(15)), '0, '0, 1'b0);
         else if (pick < 87)
            send(OP_ENABLE, 4'($urandom_range(15)), '0, '0, 1'b0);
         else if (pick < 90)
            fill_table();
         else
            send(3'($urandom_range(7)), 4'($urandom_range(15)), 2'($urandom_range(3)),
                 random_word(), 1'($urandom_range(1)));
      end

      // ---- drain ----
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ksc_pkg.sv
rtl/key_slot_cache_with_idle_expiry.sv
bench/key_cache_checker.sv
bench/testbench.sv
